### design/pdbh_pkg.sv
// Shared types, widths and codes for the presence detector.
package pdbh_pkg;

  localparam int SAMPLE_BITS       = 18;
  localparam int FRAC_BITS         = 12;
  localparam int MAX_CALIB_SAMPLES = 4095;

  localparam int CNT_W   = $clog2(MAX_CALIB_SAMPLES + 1);
  localparam int SUM_W   = SAMPLE_BITS + CNT_W;
  localparam int BASE_W  = SAMPLE_BITS + FRAC_BITS;
  localparam int DFX_W   = BASE_W + 1;
  localparam int DELTA_W = SAMPLE_BITS + 1;
  localparam int DIVD_W  = SUM_W + FRAC_BITS;
  localparam int STEP_W  = $clog2(DIVD_W);
  localparam int TIMER_W = 16;
  localparam int DWELL_W = 32;
  localparam int THR_W   = 18;
  localparam int SHIFT_W = 5;
  localparam int EVENT_W = 2;

  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [THR_W-1:0]   ENTER_RESET = THR_W'(8000);
  localparam logic [THR_W-1:0]   EXIT_RESET  = THR_W'(4000);
  localparam logic [TIMER_W-1:0] CALIB_RESET = TIMER_W'(2000);
  localparam logic [SHIFT_W-1:0] ALPHA_RESET = SHIFT_W'(9);

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_LEAVE = 2'd2,
    EV_CALIB = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    REG_ENTER = 2'd0,
    REG_EXIT  = 2'd1,
    REG_CALIB = 2'd2,
    REG_ALPHA = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_UPD
  } back_state_t;

  typedef struct packed {
    op_t                    op;
    logic [SAMPLE_BITS-1:0] sample;
  } item_t;

  typedef struct packed {
    logic [THR_W-1:0]   enter_delta;
    logic [THR_W-1:0]   exit_delta;
    logic [TIMER_W-1:0] calib_ticks;
    logic [SHIFT_W-1:0] alpha_shift;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### design/pdbh_front.sv
// Input stage: takes items, tags them as sample or tick, hands them to the queue.
module pdbh_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic                             cmd,
  input  logic [pdbh_pkg::SAMPLE_BITS-1:0] ir_sample,
  input  logic                             fifo_full,
  output logic                             push,
  output pdbh_pkg::item_t                  push_item
);

  logic            valid_q;
  pdbh_pkg::item_t item_q;

  assign item_stall = valid_q && fifo_full;
  assign push       = valid_q && !fifo_full;
  assign push_item  = item_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (!item_stall) begin
      valid_q <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_q.op     <= cmd ? pdbh_pkg::OP_TICK : pdbh_pkg::OP_SAMPLE;
      item_q.sample <= ir_sample;
    end
  end

endmodule

### design/pdbh_fifo.sv
// Short item queue between the input stage and the execution stage.
module pdbh_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pdbh_pkg::item_t push_item,
  input  logic            pop,
  output pdbh_pkg::item_t head,
  output logic            head_valid,
  output logic            full
);

  pdbh_pkg::item_t                   mem [pdbh_pkg::FIFO_DEPTH];
  logic [pdbh_pkg::PTR_W-1:0]        wr_ptr;
  logic [pdbh_pkg::PTR_W-1:0]        rd_ptr;
  logic [pdbh_pkg::FCNT_W-1:0]       count;

  assign head       = mem[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == pdbh_pkg::FCNT_W'(pdbh_pkg::FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + pdbh_pkg::PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + pdbh_pkg::PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + pdbh_pkg::FCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - pdbh_pkg::FCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

### design/pdbh_div.sv
// Radix-2 restoring divider for the calibration average, one quotient bit a cycle.
module pdbh_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pdbh_pkg::DIVD_W-1:0] dividend,
  input  logic [pdbh_pkg::CNT_W-1:0]  divisor,
  output pdbh_pkg::div_status_t       status,
  output logic [pdbh_pkg::DIVD_W-1:0] quotient
);

  logic                        busy;
  logic                        done;
  logic [pdbh_pkg::STEP_W-1:0] step;
  logic [pdbh_pkg::CNT_W-1:0]  rem;
  logic [pdbh_pkg::CNT_W-1:0]  dvs;
  logic [pdbh_pkg::DIVD_W-1:0] quo;
  logic [pdbh_pkg::CNT_W:0]    trial;
  logic [pdbh_pkg::CNT_W:0]    diff;
  logic                        ge;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem, quo[pdbh_pkg::DIVD_W-1]};
  assign ge    = (trial >= {1'b0, dvs});
  assign diff  = trial - {1'b0, dvs};

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + pdbh_pkg::STEP_W'(1);
        if (step == pdbh_pkg::STEP_W'(pdbh_pkg::DIVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[pdbh_pkg::CNT_W-1:0] : trial[pdbh_pkg::CNT_W-1:0];
      quo <= {quo[pdbh_pkg::DIVD_W-2:0], ge};
    end
  end

endmodule

### design/pdbh_back.sv
// Execution stage: calibration, thresholds, baseline tracking and the result register.
module pdbh_back (
  input  logic                                clk,
  input  logic                                rst,
  input  pdbh_pkg::cfg_t                      cfg,
  input  pdbh_pkg::item_t                     head,
  input  logic                                head_valid,
  output logic                                pop,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [pdbh_pkg::EVENT_W-1:0]        event_res,
  output logic                                present,
  output logic signed [pdbh_pkg::DELTA_W-1:0] delta,
  output logic [pdbh_pkg::DWELL_W-1:0]        dwell_ticks,
  output logic [pdbh_pkg::SAMPLE_BITS-1:0]    baseline_level
);

  pdbh_pkg::back_state_t state, state_next;

  // architectural state
  logic                              calibrating;
  logic [pdbh_pkg::SUM_W-1:0]        calib_sum;
  logic [pdbh_pkg::CNT_W-1:0]        calib_count;
  logic [pdbh_pkg::TIMER_W-1:0]      calib_timer;
  logic [pdbh_pkg::BASE_W-1:0]       baseline_fx;
  logic                              object_here;
  logic [pdbh_pkg::DWELL_W-1:0]      dwell_counter;

  // evaluated item
  pdbh_pkg::op_t                     ex_op;
  logic [pdbh_pkg::SAMPLE_BITS-1:0]  ex_sample;
  logic signed [pdbh_pkg::DFX_W-1:0] ex_dfx;
  logic                              ex_enter;
  logic                              ex_leave;
  logic [pdbh_pkg::TIMER_W-1:0]      ex_timer;
  logic                              ex_done;

  // front-of-queue evaluation
  logic signed [pdbh_pkg::DFX_W-1:0] dfx;
  logic signed [pdbh_pkg::DFX_W-1:0] enter_fx;
  logic signed [pdbh_pkg::DFX_W-1:0] exit_fx;
  logic [pdbh_pkg::TIMER_W-1:0]      tick_timer;
  logic                              tick_done;
  logic                              enter_hit;
  logic                              leave_hit;

  // update values
  logic                              calibrating_next;
  logic [pdbh_pkg::SUM_W-1:0]        calib_sum_next;
  logic [pdbh_pkg::CNT_W-1:0]        calib_count_next;
  logic [pdbh_pkg::TIMER_W-1:0]      calib_timer_next;
  logic [pdbh_pkg::BASE_W-1:0]       baseline_next;
  logic                              object_here_next;
  logic [pdbh_pkg::DWELL_W-1:0]      dwell_next;
  pdbh_pkg::event_t                  ev;
  logic [pdbh_pkg::DELTA_W-1:0]      delta_v;
  logic [pdbh_pkg::DWELL_W-1:0]      dwell_v;
  logic signed [pdbh_pkg::DFX_W-1:0] trk_step;
  logic signed [pdbh_pkg::DFX_W:0]   trk_sum;

  logic                              out_free;
  logic                              out_load;
  logic                              div_start;
  pdbh_pkg::div_status_t             div_st;
  logic [pdbh_pkg::DIVD_W-1:0]       div_quo;

  pdbh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({calib_sum, {pdbh_pkg::FRAC_BITS{1'b0}}}),
    .divisor  (calib_count),
    .status   (div_st),
    .quotient (div_quo)
  );

  assign out_free = !result_valid || !result_stall;

  always_comb begin
    dfx = $signed({1'b0, head.sample, {pdbh_pkg::FRAC_BITS{1'b0}}})
        - $signed({1'b0, baseline_fx});
    enter_fx = pdbh_pkg::DFX_W'({cfg.enter_delta, {pdbh_pkg::FRAC_BITS{1'b0}}});
    exit_fx  = pdbh_pkg::DFX_W'({cfg.exit_delta, {pdbh_pkg::FRAC_BITS{1'b0}}});
    tick_timer = (calib_timer == '1) ? calib_timer
                                     : calib_timer + pdbh_pkg::TIMER_W'(1);
    tick_done  = (tick_timer >= cfg.calib_ticks);
    enter_hit  = !object_here && (dfx > enter_fx);
    leave_hit  = object_here && (dfx < exit_fx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pdbh_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      pdbh_pkg::S_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          if (head.op == pdbh_pkg::OP_TICK && calibrating && tick_done &&
              calib_count != '0) begin
            div_start  = 1'b1;
            state_next = pdbh_pkg::S_DIV;
          end else begin
            state_next = pdbh_pkg::S_UPD;
          end
        end
      end
      pdbh_pkg::S_DIV: begin
        if (div_st.done) begin
          state_next = pdbh_pkg::S_UPD;
        end
      end
      pdbh_pkg::S_UPD: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = pdbh_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pdbh_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ex_op     <= head.op;
      ex_sample <= head.sample;
      ex_dfx    <= dfx;
      ex_enter  <= enter_hit;
      ex_leave  <= leave_hit;
      ex_timer  <= tick_timer;
      ex_done   <= tick_done;
    end
  end

  // floor shift; the sum never goes below the sample, clamp kept for safety
  assign trk_step = ex_dfx >>> cfg.alpha_shift;
  assign trk_sum  = $signed({2'b00, baseline_fx}) + {trk_step[pdbh_pkg::DFX_W-1], trk_step};

  always_comb begin
    calibrating_next = calibrating;
    calib_sum_next   = calib_sum;
    calib_count_next = calib_count;
    calib_timer_next = calib_timer;
    baseline_next    = baseline_fx;
    object_here_next = object_here;
    dwell_next       = dwell_counter;
    ev               = pdbh_pkg::EV_NONE;
    delta_v          = '0;
    dwell_v          = '0;
    if (ex_op == pdbh_pkg::OP_TICK) begin
      if (calibrating) begin
        calib_timer_next = ex_timer;
        if (ex_done) begin
          baseline_next    = (calib_count != '0) ? div_quo[pdbh_pkg::BASE_W-1:0] : '0;
          calibrating_next = 1'b0;
          ev               = pdbh_pkg::EV_CALIB;
        end
      end else if (object_here && dwell_counter != '1) begin
        dwell_next = dwell_counter + pdbh_pkg::DWELL_W'(1);
      end
    end else if (calibrating) begin
      if (calib_count < pdbh_pkg::CNT_W'(pdbh_pkg::MAX_CALIB_SAMPLES)) begin
        calib_sum_next   = calib_sum + pdbh_pkg::SUM_W'(ex_sample);
        calib_count_next = calib_count + pdbh_pkg::CNT_W'(1);
      end
    end else begin
      delta_v = ex_dfx[pdbh_pkg::DFX_W-1:pdbh_pkg::FRAC_BITS];
      if (ex_enter) begin
        object_here_next = 1'b1;
        dwell_next       = '0;
        ev               = pdbh_pkg::EV_ENTER;
      end else if (ex_leave) begin
        object_here_next = 1'b0;
        dwell_v          = dwell_counter;
        ev               = pdbh_pkg::EV_LEAVE;
      end
      if (!object_here_next) begin
        baseline_next = trk_sum[pdbh_pkg::DFX_W] ? '0 : trk_sum[pdbh_pkg::BASE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      calibrating   <= 1'b1;
      calib_sum     <= '0;
      calib_count   <= '0;
      calib_timer   <= '0;
      baseline_fx   <= '0;
      object_here   <= 1'b0;
      dwell_counter <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        calibrating   <= calibrating_next;
        calib_sum     <= calib_sum_next;
        calib_count   <= calib_count_next;
        calib_timer   <= calib_timer_next;
        baseline_fx   <= baseline_next;
        object_here   <= object_here_next;
        dwell_counter <= dwell_next;
        result_valid  <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      event_res      <= ev;
      present        <= object_here_next;
      delta          <= $signed(delta_v);
      dwell_ticks    <= dwell_v;
      baseline_level <= baseline_next[pdbh_pkg::BASE_W-1:pdbh_pkg::FRAC_BITS];
    end
  end

  a_div_only_calib: assert property (@(posedge clk) disable iff (rst)
    div_start |-> calibrating && calib_count != '0)
    else $error("divider started outside calibration or with no samples");

  a_leave_clears: assert property (@(posedge clk) disable iff (rst)
    result_valid && event_res == pdbh_pkg::EV_LEAVE |-> !present)
    else $error("leave event with presence still set");

  a_calib_once: assert property (@(posedge clk) disable iff (rst)
    !calibrating |=> !calibrating)
    else $error("calibration restarted without reset");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    state == pdbh_pkg::S_DIV |-> div_st.busy || div_st.done)
    else $error("waiting on a divider that is not running");

endmodule

### design/presence_detect_baseline_hysteresis.sv
// Top level of the presence detector: register port and the three stages.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------------------
//  item     | item_valid / item_stall   | cmd, ir_sample
//  result   | result_valid/result_stall | event_res, present, delta, dwell_ticks,
//           |                           | baseline_level
//  register | psel, penable, pwrite     | paddr, pwdata, prdata (pready tied high)
//
// Flow: the input stage registers the item and pushes it into the queue; the execution
//   stage evaluates it at the queue head, then updates state and loads the result
//   register, which waits while result_stall holds it. The tick that ends calibration
//   with samples in hand first runs the 42-step restoring divider.
// Reset: synchronous, active high; registers return to 8000/4000/2000/9 and the
//   detector re-enters calibration. No memory to clear.
// Stalls: the 2-entry queue lets the input side keep taking items while the result
//   register waits on result_stall; item_stall rises only when the input stage
//   holds an item and the queue is full.
// Registers: enter_delta 0x0, exit_delta 0x4, calib_ticks 0x8, alpha_shift 0xC.
module presence_detect_baseline_hysteresis (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic                                cmd,
  input  logic [pdbh_pkg::SAMPLE_BITS-1:0]    ir_sample,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [pdbh_pkg::EVENT_W-1:0]        event_res,
  output logic                                present,
  output logic signed [pdbh_pkg::DELTA_W-1:0] delta,
  output logic [pdbh_pkg::DWELL_W-1:0]        dwell_ticks,
  output logic [pdbh_pkg::SAMPLE_BITS-1:0]    baseline_level,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pdbh_pkg::ADDR_W-1:0]         paddr,
  input  logic [pdbh_pkg::DATA_W-1:0]         pwdata,
  output logic [pdbh_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  pdbh_pkg::cfg_t     cfg;
  pdbh_pkg::reg_idx_t reg_idx;
  logic               reg_wr;

  logic               push;
  pdbh_pkg::item_t    push_item;
  logic               fifo_full;
  logic               pop;
  pdbh_pkg::item_t    head;
  logic               head_valid;

  assign pready  = 1'b1;
  // word address; the low byte bits are ignored
  assign reg_idx = pdbh_pkg::reg_idx_t'(paddr[3:2]);
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enter_delta <= pdbh_pkg::ENTER_RESET;
      cfg.exit_delta  <= pdbh_pkg::EXIT_RESET;
      cfg.calib_ticks <= pdbh_pkg::CALIB_RESET;
      cfg.alpha_shift <= pdbh_pkg::ALPHA_RESET;
    end else if (reg_wr) begin
      unique case (reg_idx)
        pdbh_pkg::REG_ENTER: cfg.enter_delta <= pwdata[pdbh_pkg::THR_W-1:0];
        pdbh_pkg::REG_EXIT:  cfg.exit_delta  <= pwdata[pdbh_pkg::THR_W-1:0];
        pdbh_pkg::REG_CALIB: cfg.calib_ticks <= pwdata[pdbh_pkg::TIMER_W-1:0];
        pdbh_pkg::REG_ALPHA: cfg.alpha_shift <= pwdata[pdbh_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      pdbh_pkg::REG_ENTER: prdata = pdbh_pkg::DATA_W'(cfg.enter_delta);
      pdbh_pkg::REG_EXIT:  prdata = pdbh_pkg::DATA_W'(cfg.exit_delta);
      pdbh_pkg::REG_CALIB: prdata = pdbh_pkg::DATA_W'(cfg.calib_ticks);
      pdbh_pkg::REG_ALPHA: prdata = pdbh_pkg::DATA_W'(cfg.alpha_shift);
      default:             prdata = '0;
    endcase
  end

  pdbh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .cmd        (cmd),
    .ir_sample  (ir_sample),
    .fifo_full  (fifo_full),
    .push       (push),
    .push_item  (push_item)
  );

  pdbh_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (fifo_full)
  );

  pdbh_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .head           (head),
    .head_valid     (head_valid),
    .pop            (pop),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .event_res      (event_res),
    .present        (present),
    .delta          (delta),
    .dwell_ticks    (dwell_ticks),
    .baseline_level (baseline_level)
  );

endmodule
